/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
// Plain text only; nothing here depends on any other file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PPT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ppt assertion failed");

// Next-cycle implication, disabled while reset is low.
`define PPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ppt assertion failed");

`endif

/* rtl/ppt_pkg.sv */
// Shared constants, codes, types and helper functions of the pure-pursuit
// target finder. No dependencies.
package ppt_pkg;

    localparam int MAX_POINTS = 64;
    localparam int PTR_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = PTR_W + 1;

    localparam int COORD_W = 32;
    localparam int DIST_W  = 31;
    localparam int REQ_W   = 2;
    localparam int START_W = 6;
    localparam int SEG_W   = 7;
    localparam int STAT_W  = 3;
    localparam int LOC_W   = 31;
    localparam int MOP_W   = 33;
    localparam int ACC_W   = 128;

    localparam logic [DIST_W-1:0]    LOOK_RESET = 31'd786432;
    localparam logic signed [32:0]   LOCAL_LIM  = 33'sd536870912;
    localparam logic signed [33:0]   SAT_HI     = 34'sd2147483647;
    localparam logic signed [33:0]   SAT_LO     = -34'sd2147483648;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_START  = 2'd2,
        REQ_UPDATE = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_CAPTURED = 3'd1,
        STAT_INLOOK   = 3'd2,
        STAT_INTER    = 3'd3,
        STAT_HELD     = 3'd4,
        STAT_FULL     = 3'd5,
        STAT_END      = 3'd6
    } t_status;

    // One multiply-accumulate term: acc = (clr ? 0 : acc) +/- (a * b) << (32 * sh)
    typedef struct packed {
        logic             vld;
        logic             clr;
        logic             neg;
        logic [1:0]       sh;
        logic [MOP_W-1:0] a;
        logic [MOP_W-1:0] b;
    } t_mac_op;

    function automatic logic signed [LOC_W-1:0] clamp_local(input logic signed [32:0] v);
        logic signed [LOC_W-1:0] r;
        if (v > LOCAL_LIM) begin
            r = LOC_W'(LOCAL_LIM);
        end else if (v < -LOCAL_LIM) begin
            r = LOC_W'(-LOCAL_LIM);
        end else begin
            r = LOC_W'(v);
        end
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [33:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > SAT_HI) begin
            r = COORD_W'(SAT_HI);
        end else if (v < SAT_LO) begin
            r = COORD_W'(SAT_LO);
        end else begin
            r = COORD_W'(v);
        end
        return r;
    endfunction

endpackage

/* rtl/ppt_ifs.sv */
// Valid/ready channel interfaces of the target finder: request, result and
// configuration write. Depends on ppt_pkg.
interface ppt_req_if;
    import ppt_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [REQ_W-1:0]          req_type;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic [DIST_W-1:0]         advance_dist;
    logic [START_W-1:0]        start_index;

    modport source (output valid, req_type, coord_x, coord_y, advance_dist, start_index,
                    input ready);
    modport sink   (input valid, req_type, coord_x, coord_y, advance_dist, start_index,
                    output ready);
endinterface

interface ppt_res_if;
    import ppt_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic [SEG_W-1:0]          segment_index;
    logic [STAT_W-1:0]         status;

    modport source (output valid, target_x, target_y, segment_index, status, input ready);
    modport sink   (input valid, target_x, target_y, segment_index, status, output ready);
endinterface

interface ppt_cfg_if;
    import ppt_pkg::*;
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* rtl/ppt_mac.sv */
// Shared multiply-accumulate unit: 33x33 signed product, registered, then a
// 128-bit add or subtract at a 32-bit word offset. Depends on ppt_pkg.
module ppt_mac (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ppt_pkg::t_mac_op                i_op,
    output logic signed [ppt_pkg::ACC_W-1:0] o_acc
);
    import ppt_pkg::*;

    logic                        r_vld;
    logic                        r_clr;
    logic                        r_neg;
    logic [1:0]                  r_sh;
    logic signed [2*MOP_W-1:0]   r_p;
    logic signed [ACC_W-1:0]     r_acc;
    logic signed [ACC_W-1:0]     w_ext;
    logic signed [ACC_W-1:0]     w_term;
    logic signed [ACC_W-1:0]     w_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_op.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p   <= $signed(i_op.a) * $signed(i_op.b);
        r_clr <= i_op.clr;
        r_neg <= i_op.neg;
        r_sh  <= i_op.sh;
    end

    assign w_ext = ACC_W'(r_p);

    always_comb begin
        case (r_sh)
            2'd0:    w_term = w_ext;
            2'd1:    w_term = w_ext <<< 32;
            2'd2:    w_term = w_ext <<< 64;
            default: w_term = w_ext <<< 96;
        endcase
    end

    assign w_base = r_clr ? '0 : r_acc;

    always_ff @(posedge i_clk) begin
        if (r_vld) begin
            r_acc <= r_neg ? (w_base - w_term) : (w_base + w_term);
        end
    end

    assign o_acc = r_acc;
endmodule

/* rtl/pure_pursuit_target_finder.sv */
// Pure-pursuit target finder: one result beat per request beat. A pose update
// that ends in the intersection step runs a 64-step square root and two 31-step
// divisions, with its products formed on one shared multiply-accumulate unit.
// Requests are taken only while the sequencer is idle; a finished result waits
// in an output register, so the next request may enter before it is taken.
// Waypoints live in a 64-entry table with one write port and one registered
// read port. Depends on ppt_pkg, ppt_ifs, ppt_mac.
module pure_pursuit_target_finder (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ppt_cfg_if.sink  i_cfg,
    ppt_req_if.sink  i_req,
    ppt_res_if.source o_res
);
    import ppt_pkg::*;

    typedef enum logic [16:0] {
        ST_IDLE = 17'h00001,
        ST_STA  = 17'h00002,
        ST_RD_B = 17'h00004,
        ST_RD_A = 17'h00008,
        ST_CAPV = 17'h00010,
        ST_CAPR = 17'h00020,
        ST_DEC  = 17'h00040,
        ST_A    = 17'h00080,
        ST_B    = 17'h00100,
        ST_C    = 17'h00200,
        ST_DISC = 17'h00400,
        ST_SQRT = 17'h00800,
        ST_PICK = 17'h01000,
        ST_PROD = 17'h02000,
        ST_DIV  = 17'h04000,
        ST_AIM  = 17'h08000,
        ST_OUT  = 17'h10000
    } t_state;

    typedef struct packed {
        logic [DIST_W-1:0]  adv;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } t_way;

    localparam int Q_W  = 31;
    localparam int PR_W = 92;

    // control state
    t_state                    r_state, n_state;
    logic [DIST_W-1:0]         r_look;
    logic [CNT_W-1:0]          r_pc, n_pc;
    logic [CNT_W-1:0]          r_seg, n_seg;
    logic signed [COORD_W-1:0] r_org_x, n_org_x, r_org_y, n_org_y;
    logic signed [COORD_W-1:0] r_aim_x, n_aim_x, r_aim_y, n_aim_y;
    t_status                   r_stat, n_stat;
    logic [3:0]                r_k, n_k;
    logic                      r_ov;

    // output register
    logic signed [COORD_W-1:0] r_ox, r_oy;
    logic [SEG_W-1:0]          r_oseg;
    t_status                   r_ostat;

    // waypoint table
    t_way                      r_way_mem [MAX_POINTS];
    t_way                      r_rd;
    logic [PTR_W-1:0]          w_raddr;

    // datapath
    logic signed [COORD_W-1:0] r_px, r_py, r_x2, r_y2;
    logic [DIST_W-1:0]         r_adv;
    logic signed [LOC_W-1:0]   r_l1x, r_l1y, r_l2x, r_l2y;
    logic signed [COORD_W-1:0] r_dx, r_dy;
    logic                      r_lt_adv, r_lt_r;
    logic [63:0]               r_a;
    logic signed [63:0]        r_b, r_c;
    logic [ACC_W-1:0]          r_sq_v;
    logic [65:0]               r_rem;
    logic [63:0]               r_root;
    logic [5:0]                r_it;
    logic [63:0]               r_num;
    logic [63:0]               r_dv_rem;
    logic [Q_W-1:0]            r_dv_sh;
    logic [Q_W-1:0]            r_q;
    logic                      r_axis;
    logic signed [COORD_W-1:0] r_offx, r_offy;

    logic                      w_in_acc, w_out_acc, w_out_load;
    logic [CNT_W-1:0]          w_si, w_last, w_si_c, w_segm1;
    logic                      w_si_big;
    logic signed [COORD_W-1:0] w_x1, w_y1;
    t_mac_op                   w_op;
    logic signed [ACC_W-1:0]   w_acc;
    logic [3:0]                w_cap_k;
    logic                      w_cap;
    logic [63:0]               w_bmag, w_cmag;
    logic                      w_csub;
    logic [67:0]               w_sq_t, w_sq_trial;
    logic                      w_sq_ge;
    logic signed [65:0]        w_n2, w_n1;
    logic                      w_ok2, w_ok1;
    logic [COORD_W-1:0]        w_dmag;
    logic                      w_dneg;
    logic [63:0]               w_dv_t;
    logic                      w_dv_ge;
    logic [Q_W-1:0]            w_q;
    logic signed [COORD_W-1:0] w_off;

    function automatic t_mac_op mk_op(input logic [MOP_W-1:0] a, input logic [MOP_W-1:0] b,
                                      input logic clr, input logic neg,
                                      input logic [1:0] sh);
        t_mac_op op;
        op.vld = 1'b1;
        op.clr = clr;
        op.neg = neg;
        op.sh  = sh;
        op.a   = a;
        op.b   = b;
        return op;
    endfunction

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == ST_IDLE);
    assign w_in_acc    = i_req.valid & i_req.ready;
    assign w_out_acc   = o_res.valid & o_res.ready;
    assign w_out_load  = (r_state == ST_OUT) && (!r_ov || w_out_acc);

    assign o_res.valid         = r_ov;
    assign o_res.target_x      = r_ox;
    assign o_res.target_y      = r_oy;
    assign o_res.segment_index = r_oseg;
    assign o_res.status        = r_ostat;

    // start index, saturated to the last segment
    assign w_si     = CNT_W'(i_req.start_index);
    assign w_last   = r_pc - 1'b1;
    assign w_si_big = w_si > w_last;
    assign w_si_c   = w_si_big ? w_last : w_si;
    assign w_segm1  = r_seg - 1'b1;

    always_comb begin
        case (r_state)
            ST_IDLE: w_raddr = (t_req'(i_req.req_type) == REQ_START) ? w_si_c[PTR_W-1:0]
                                                                       : r_seg[PTR_W-1:0];
            ST_RD_B: w_raddr = w_segm1[PTR_W-1:0];
            default: w_raddr = r_seg[PTR_W-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (t_req'(i_req.req_type) == REQ_APPEND)
                && (r_pc < CNT_W'(MAX_POINTS))) begin
            r_way_mem[r_pc[PTR_W-1:0]] <= {i_req.advance_dist, i_req.coord_y, i_req.coord_x};
        end
        r_rd <= r_way_mem[w_raddr];
    end

    assign w_x1 = (r_seg == '0) ? r_org_x : $signed(r_rd.x);
    assign w_y1 = (r_seg == '0) ? r_org_y : $signed(r_rd.y);

    // magnitudes and sign handling for the wide products
    assign w_bmag = r_b[63] ? 64'(-r_b) : 64'(r_b);
    assign w_cmag = r_c[63] ? 64'(-r_c) : 64'(r_c);
    assign w_csub = !r_c[63] && (r_c != '0);
    assign w_dmag = r_axis ? (r_dy[COORD_W-1] ? 32'(-r_dy) : 32'(r_dy))
                           : (r_dx[COORD_W-1] ? 32'(-r_dx) : 32'(r_dx));
    assign w_dneg = r_axis ? r_dy[COORD_W-1] : r_dx[COORD_W-1];

    always_comb begin
        w_op = '0;
        case (r_state)
            ST_CAPV, ST_CAPR: begin
                case (r_k)
                    4'd0: w_op = mk_op(MOP_W'(r_l2x), MOP_W'(r_l2x), 1'b1, 1'b0, 2'd0);
                    4'd1: w_op = mk_op(MOP_W'(r_l2y), MOP_W'(r_l2y), 1'b0, 1'b0, 2'd0);
                    4'd2: w_op = (r_state == ST_CAPV)
                               ? mk_op(MOP_W'(r_adv), MOP_W'(r_adv), 1'b0, 1'b1, 2'd0)
                               : mk_op(MOP_W'(r_look), MOP_W'(r_look), 1'b0, 1'b1, 2'd0);
                    default: w_op = '0;
                endcase
            end
            ST_A: begin
                case (r_k)
                    4'd0: w_op = mk_op(MOP_W'(r_dx), MOP_W'(r_dx), 1'b1, 1'b0, 2'd0);
                    4'd1: w_op = mk_op(MOP_W'(r_dy), MOP_W'(r_dy), 1'b0, 1'b0, 2'd0);
                    default: w_op = '0;
                endcase
            end
            ST_B: begin
                case (r_k)
                    4'd0: w_op = mk_op(MOP_W'(r_l1x), MOP_W'(r_dx), 1'b1, 1'b0, 2'd0);
                    4'd1: w_op = mk_op(MOP_W'(r_l1y), MOP_W'(r_dy), 1'b0, 1'b0, 2'd0);
                    default: w_op = '0;
                endcase
            end
            ST_C: begin
                case (r_k)
                    4'd0: w_op = mk_op(MOP_W'(r_l1x), MOP_W'(r_l1x), 1'b1, 1'b0, 2'd0);
                    4'd1: w_op = mk_op(MOP_W'(r_l1y), MOP_W'(r_l1y), 1'b0, 1'b0, 2'd0);
                    4'd2: w_op = mk_op(MOP_W'(r_look), MOP_W'(r_look), 1'b0, 1'b1, 2'd0);
                    default: w_op = '0;
                endcase
            end
            ST_DISC: begin
                // b*b, then add or subtract a*|c|, 32-bit limbs
                case (r_k)
                    4'd0: w_op = mk_op({1'b0, w_bmag[31:0]}, {1'b0, w_bmag[31:0]},
                                       1'b1, 1'b0, 2'd0);
                    4'd1: w_op = mk_op({1'b0, w_bmag[31:0]}, {1'b0, w_bmag[63:32]},
                                       1'b0, 1'b0, 2'd1);
                    4'd2: w_op = mk_op({1'b0, w_bmag[63:32]}, {1'b0, w_bmag[31:0]},
                                       1'b0, 1'b0, 2'd1);
                    4'd3: w_op = mk_op({1'b0, w_bmag[63:32]}, {1'b0, w_bmag[63:32]},
                                       1'b0, 1'b0, 2'd2);
                    4'd4: w_op = mk_op({1'b0, r_a[31:0]}, {1'b0, w_cmag[31:0]},
                                       1'b0, w_csub, 2'd0);
                    4'd5: w_op = mk_op({1'b0, r_a[31:0]}, {1'b0, w_cmag[63:32]},
                                       1'b0, w_csub, 2'd1);
                    4'd6: w_op = mk_op({1'b0, r_a[63:32]}, {1'b0, w_cmag[31:0]},
                                       1'b0, w_csub, 2'd1);
                    4'd7: w_op = mk_op({1'b0, r_a[63:32]}, {1'b0, w_cmag[63:32]},
                                       1'b0, w_csub, 2'd2);
                    default: w_op = '0;
                endcase
            end
            ST_PROD: begin
                case (r_k)
                    4'd0: w_op = mk_op({1'b0, w_dmag}, {1'b0, r_num[31:0]}, 1'b1, 1'b0, 2'd0);
                    4'd1: w_op = mk_op({1'b0, w_dmag}, {1'b0, r_num[63:32]}, 1'b0, 1'b0, 2'd1);
                    default: w_op = '0;
                endcase
            end
            default: w_op = '0;
        endcase
    end

    ppt_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .o_acc   (w_acc)
    );

    // r_acc holds the finished sum once the last term passes r_p and r_acc
    always_comb begin
        case (r_state)
            ST_CAPV, ST_CAPR, ST_C: w_cap_k = 4'd4;
            ST_A, ST_B, ST_PROD:    w_cap_k = 4'd3;
            ST_DISC:                w_cap_k = 4'd9;
            default:                w_cap_k = 4'd0;
        endcase
    end
    assign w_cap = (r_k == w_cap_k);

    // square root, one result bit a step from two radicand bits
    assign w_sq_t     = {r_rem, r_sq_v[ACC_W-1 -: 2]};
    assign w_sq_trial = {2'b00, r_root, 2'b01};
    assign w_sq_ge    = w_sq_t >= w_sq_trial;

    // candidate numerators of the two roots
    assign w_n2  = $signed({2'b00, r_root}) - 66'(r_b);
    assign w_n1  = -$signed({2'b00, r_root}) - 66'(r_b);
    assign w_ok2 = !w_n2[65] && ($unsigned(w_n2) <= {2'b00, r_a});
    assign w_ok1 = !w_n1[65] && ($unsigned(w_n1) <= {2'b00, r_a});

    // restoring division, one quotient bit a step
    assign w_dv_t  = {r_dv_rem[62:0], r_dv_sh[Q_W-1]};
    assign w_dv_ge = w_dv_t >= r_a;
    assign w_q     = {r_q[Q_W-2:0], w_dv_ge};
    assign w_off   = w_dneg ? -COORD_W'(w_q) : COORD_W'(w_q);

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_seg   = r_seg;
        n_org_x = r_org_x;
        n_org_y = r_org_y;
        n_aim_x = r_aim_x;
        n_aim_y = r_aim_y;
        n_stat  = r_stat;
        n_k     = r_k + 1'b1;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_stat  = STAT_OK;
                    n_state = ST_OUT;
                    case (t_req'(i_req.req_type))
                        REQ_CLEAR: begin
                            n_pc  = '0;
                            n_seg = '0;
                        end
                        REQ_APPEND: begin
                            if (r_pc < CNT_W'(MAX_POINTS)) begin
                                n_pc = r_pc + 1'b1;
                            end else begin
                                n_stat = STAT_FULL;
                            end
                        end
                        REQ_START: begin
                            n_org_x = i_req.coord_x;
                            n_org_y = i_req.coord_y;
                            if (r_pc == '0) begin
                                n_seg   = '0;
                                n_aim_x = i_req.coord_x;
                                n_aim_y = i_req.coord_y;
                                n_stat  = STAT_END;
                            end else begin
                                n_seg   = w_si_c;
                                n_stat  = w_si_big ? STAT_END : STAT_OK;
                                n_state = ST_STA;
                            end
                        end
                        REQ_UPDATE: begin
                            if (r_seg >= r_pc) begin
                                n_stat = STAT_END;
                            end else begin
                                n_state = ST_RD_B;
                            end
                        end
                        default: n_state = ST_OUT;
                    endcase
                end
            end
            ST_STA: begin
                n_aim_x = $signed(r_rd.x);
                n_aim_y = $signed(r_rd.y);
                n_state = ST_OUT;
            end
            ST_RD_B: n_state = ST_RD_A;
            ST_RD_A: n_state = ST_CAPV;
            ST_CAPV: if (w_cap) n_state = ST_CAPR;
            ST_CAPR: if (w_cap) n_state = ST_DEC;
            ST_DEC: begin
                if (r_lt_adv) begin
                    n_aim_x = r_x2;
                    n_aim_y = r_y2;
                    n_seg   = r_seg + 1'b1;
                    n_stat  = STAT_CAPTURED;
                    n_state = ST_OUT;
                end else if (r_lt_r) begin
                    n_aim_x = r_x2;
                    n_aim_y = r_y2;
                    n_stat  = STAT_INLOOK;
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_A;
                end
            end
            ST_A: begin
                if (w_cap) begin
                    if (w_acc == '0) begin
                        n_stat  = STAT_HELD;
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_B;
                    end
                end
            end
            ST_B: if (w_cap) n_state = ST_C;
            ST_C: if (w_cap) n_state = ST_DISC;
            ST_DISC: begin
                if (w_cap) begin
                    if (w_acc[ACC_W-1]) begin
                        n_stat  = STAT_HELD;
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_SQRT;
                    end
                end
            end
            ST_SQRT: if (r_it == '0) n_state = ST_PICK;
            ST_PICK: begin
                if (w_ok2 || w_ok1) begin
                    n_state = ST_PROD;
                end else begin
                    n_stat  = STAT_HELD;
                    n_state = ST_OUT;
                end
            end
            ST_PROD: if (w_cap) n_state = ST_DIV;
            ST_DIV: begin
                if (r_it == '0) begin
                    n_state = r_axis ? ST_AIM : ST_PROD;
                end
            end
            ST_AIM: begin
                n_aim_x = sat32(34'(r_px) + 34'(r_l1x) + 34'(r_offx));
                n_aim_y = sat32(34'(r_py) + 34'(r_l1y) + 34'(r_offy));
                n_stat  = STAT_INTER;
                n_state = ST_OUT;
            end
            ST_OUT: if (!r_ov || w_out_acc) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
        if (n_state != r_state) begin
            n_k = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_look  <= LOOK_RESET;
            r_pc    <= '0;
            r_seg   <= '0;
            r_org_x <= '0;
            r_org_y <= '0;
            r_aim_x <= '0;
            r_aim_y <= '0;
            r_stat  <= STAT_OK;
            r_k     <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_seg   <= n_seg;
            r_org_x <= n_org_x;
            r_org_y <= n_org_y;
            r_aim_x <= n_aim_x;
            r_aim_y <= n_aim_y;
            r_stat  <= n_stat;
            r_k     <= n_k;
            if (i_cfg.valid && i_cfg.ready) begin
                r_look <= i_cfg.data;
            end
            if (w_out_load) begin
                r_ov <= 1'b1;
            end else if (w_out_acc) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_ox    <= r_aim_x;
            r_oy    <= r_aim_y;
            r_oseg  <= SEG_W'(r_seg);
            r_ostat <= r_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    r_px <= i_req.coord_x;
                    r_py <= i_req.coord_y;
                end
            end
            ST_RD_B: begin
                r_x2  <= $signed(r_rd.x);
                r_y2  <= $signed(r_rd.y);
                r_adv <= r_rd.adv;
            end
            ST_RD_A: begin
                r_l1x <= clamp_local(33'(w_x1) - 33'(r_px));
                r_l1y <= clamp_local(33'(w_y1) - 33'(r_py));
                r_l2x <= clamp_local(33'(r_x2) - 33'(r_px));
                r_l2y <= clamp_local(33'(r_y2) - 33'(r_py));
            end
            ST_CAPV: begin
                r_dx <= COORD_W'(r_l2x) - COORD_W'(r_l1x);
                r_dy <= COORD_W'(r_l2y) - COORD_W'(r_l1y);
                if (w_cap) r_lt_adv <= w_acc[ACC_W-1];
            end
            ST_CAPR: if (w_cap) r_lt_r <= w_acc[ACC_W-1];
            ST_A:    if (w_cap) r_a <= w_acc[63:0];
            ST_B:    if (w_cap) r_b <= w_acc[63:0];
            ST_C:    if (w_cap) r_c <= w_acc[63:0];
            ST_DISC: begin
                if (w_cap) begin
                    r_sq_v <= w_acc;
                    r_rem  <= '0;
                    r_root <= '0;
                    r_it   <= '1;
                end
            end
            ST_SQRT: begin
                r_rem  <= w_sq_ge ? 66'(w_sq_t - w_sq_trial) : w_sq_t[65:0];
                r_root <= {r_root[62:0], w_sq_ge};
                r_sq_v <= r_sq_v << 2;
                r_it   <= r_it - 1'b1;
            end
            ST_PICK: begin
                r_num  <= w_ok2 ? w_n2[63:0] : w_n1[63:0];
                r_axis <= 1'b0;
            end
            ST_PROD: begin
                if (w_cap) begin
                    r_dv_rem <= 64'(w_acc[PR_W-1:Q_W]);
                    r_dv_sh  <= w_acc[Q_W-1:0];
                    r_q      <= '0;
                    r_it     <= 6'(Q_W - 1);
                end
            end
            ST_DIV: begin
                r_dv_rem <= w_dv_ge ? (w_dv_t - r_a) : w_dv_t;
                r_dv_sh  <= r_dv_sh << 1;
                r_q      <= w_q;
                r_it     <= r_it - 1'b1;
                if (r_it == '0) begin
                    if (r_axis) begin
                        r_offy <= w_off;
                    end else begin
                        r_offx <= w_off;
                    end
                    r_axis <= 1'b1;
                end
            end
            default: ;
        endcase
    end
endmodule

/* rtl/ppt_chk.sv */
// Port-level checker of the target finder, attached by bind below.
// Depends on ppt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ppt_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_req_valid,
    input logic                       i_req_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [ppt_pkg::COORD_W-1:0] i_tx,
    input logic [ppt_pkg::COORD_W-1:0] i_ty,
    input logic [ppt_pkg::SEG_W-1:0]   i_seg,
    input logic [ppt_pkg::STAT_W-1:0]  i_status
);
    import ppt_pkg::*;

    logic                                 w_req_beat;
    logic                                 w_res_stall;
    logic [2*COORD_W+SEG_W+STAT_W-1:0]    w_res_bus;
    logic                                 w_fields_ok;

    assign w_req_beat  = i_req_valid && i_req_ready;
    assign w_res_stall = i_out_valid && !i_out_ready;
    assign w_res_bus   = {i_tx, i_ty, i_seg, i_status};
    assign w_fields_ok = (i_status <= STAT_END) && (i_seg <= SEG_W'(MAX_POINTS))
                         && ((i_status != STAT_CAPTURED) || (i_seg != '0));

    // a stalled result beat holds
    `PPT_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, w_res_stall, i_out_valid && $stable(w_res_bus))

    // the sequencer goes busy after every request beat
    `PPT_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, w_req_beat, !i_req_ready)

    // no result can appear in the cycle right after a request beat
    `PPT_ASSERT_NEXT(a_no_instant_res, i_clk, i_rst_n, w_req_beat, !$rose(i_out_valid))

    // status in range, index at most the table size, a capture always moves past segment zero
    `PPT_ASSERT_SAME(a_res_fields, i_clk, i_rst_n, i_out_valid, w_fields_ok)
endmodule

bind pure_pursuit_target_finder ppt_chk u_ppt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_tx        (o_res.target_x),
    .i_ty        (o_res.target_y),
    .i_seg       (o_res.segment_index),
    .i_status    (o_res.status)
);

/* verif/tb.sv */
// Self-checking testbench of pure_pursuit_target_finder: directed geometry, table fill,
// lookahead sweep and output back-pressure. Depends on the DUT, ppt_pkg and ppt_ifs.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ppt_pkg::*;

    localparam int U          = 65536;
    localparam int WDOG_LIMIT = 5000;
    localparam int MAX_SHOWN  = 10;

    typedef struct {
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic [6:0]         seg;
        t_status            st;
    } t_aim_rec;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ppt_req_if req_if ();
    ppt_res_if res_if ();
    ppt_cfg_if cfg_if ();

    pure_pursuit_target_finder DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_if.sink),
        .i_req  (req_if.sink),
        .o_res  (res_if.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow state of the finder
    logic signed [31:0] path_x [MAX_POINTS];
    logic signed [31:0] path_y [MAX_POINTS];
    logic [30:0]        path_adv [MAX_POINTS];
    int unsigned        path_len;
    longint             org_x, org_y;
    int unsigned        seg_cur;
    longint             aim_x, aim_y;
    longint unsigned    look_r;

    t_aim_rec pending_aims [$];
    int       mismatches;
    bit       failed;
    int       items_sent;
    int       burst_left;
    bit       no_gaps;
    int       idle_cycles;
    logic     hold_req;

    function automatic longint clip_rel(input longint v);
        if (v > 64'sd536870912) return 64'sd536870912;
        if (v < -64'sd536870912) return -64'sd536870912;
        return v;
    endfunction

    function automatic longint sat_coord(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint along_axis(input longint d, input longint num,
                                          input longint unsigned a);
        logic [127:0] q;
        longint unsigned ad;
        ad = (d < 0) ? longint'(-d) : d;
        q = (128'(ad) * 128'(num)) / 128'(a);
        return (d >= 0) ? longint'(q[63:0]) : -longint'(q[63:0]);
    endfunction

    function automatic t_status track_pose(input longint px, input longint py);
        longint          x1, y1, l1x, l1y, l2x, l2y, dx, dy, b, c, n1, n2, num;
        longint unsigned adv, m2, a, s, cand, ab;
        logic [127:0]    bb, ac, disc;
        if (seg_cur >= path_len) return STAT_END;
        x1 = (seg_cur == 0) ? org_x : longint'(path_x[seg_cur-1]);
        y1 = (seg_cur == 0) ? org_y : longint'(path_y[seg_cur-1]);
        adv = path_adv[seg_cur];
        l1x = clip_rel(x1 - px);
        l1y = clip_rel(y1 - py);
        l2x = clip_rel(longint'(path_x[seg_cur]) - px);
        l2y = clip_rel(longint'(path_y[seg_cur]) - py);
        m2 = l2x * l2x + l2y * l2y;
        if (m2 < adv * adv) begin
            aim_x = path_x[seg_cur];
            aim_y = path_y[seg_cur];
            seg_cur = seg_cur + 1;
            return STAT_CAPTURED;
        end
        if (m2 < look_r * look_r) begin
            aim_x = path_x[seg_cur];
            aim_y = path_y[seg_cur];
            return STAT_INLOOK;
        end
        dx = l2x - l1x;
        dy = l2y - l1y;
        a = dx * dx + dy * dy;
        if (a == 0) return STAT_HELD;
        b = l1x * dx + l1y * dy;
        c = (l1x * l1x + l1y * l1y) - longint'(look_r * look_r);
        ab = (b < 0) ? longint'(-b) : b;
        bb = 128'(ab) * 128'(ab);
        if (c <= 0) begin
            disc = bb + 128'(a) * 128'(longint'(-c));
        end else begin
            ac = 128'(a) * 128'(c);
            if (bb < ac) return STAT_HELD;
            disc = bb - ac;
        end
        s = 0;
        for (int k = 63; k >= 0; k--) begin
            cand = s | (64'd1 << k);
            if (128'(cand) * 128'(cand) <= disc) s = cand;
        end
        n2 = -b + longint'(s);
        n1 = -b - longint'(s);
        if (n2 >= 0 && longint'(n2) <= longint'(a)) num = n2;
        else if (n1 >= 0 && longint'(n1) <= longint'(a)) num = n1;
        else return STAT_HELD;
        aim_x = sat_coord(px + l1x + along_axis(dx, num, a));
        aim_y = sat_coord(py + l1y + along_axis(dy, num, a));
        return STAT_INTER;
    endfunction

    function automatic t_aim_rec predict_aim(input t_req kind, input logic signed [31:0] x,
                                             input logic signed [31:0] y,
                                             input logic [30:0] adv, input logic [5:0] si);
        t_aim_rec    r;
        t_status     st;
        int unsigned idx;
        st = STAT_OK;
        case (kind)
            REQ_CLEAR: begin
                path_len = 0;
                seg_cur = 0;
            end
            REQ_APPEND: begin
                if (path_len < MAX_POINTS) begin
                    path_x[path_len] = x;
                    path_y[path_len] = y;
                    path_adv[path_len] = adv;
                    path_len = path_len + 1;
                end else begin
                    st = STAT_FULL;
                end
            end
            REQ_START: begin
                org_x = x;
                org_y = y;
                idx = si;
                if (path_len == 0) begin
                    seg_cur = 0;
                    aim_x = x;
                    aim_y = y;
                    st = STAT_END;
                end else begin
                    if (idx > path_len - 1) begin
                        idx = path_len - 1;
                        st = STAT_END;
                    end
                    seg_cur = idx;
                    aim_x = path_x[idx];
                    aim_y = path_y[idx];
                end
            end
            default: st = track_pose(x, y);
        endcase
        r.tx = aim_x[31:0];
        r.ty = aim_y[31:0];
        r.seg = seg_cur[6:0];
        r.st = st;
        return r;
    endfunction

    task automatic send_req(input t_req kind, input logic signed [31:0] x,
                            input logic signed [31:0] y, input logic [30:0] adv,
                            input logic [5:0] si);
        if (burst_left == 0 && !no_gaps) begin
            if ($urandom_range(0, 2) != 0) begin
                req_if.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) burst_left--;
        req_if.valid        <= 1'b1;
        req_if.req_type     <= kind;
        req_if.coord_x      <= x;
        req_if.coord_y      <= y;
        req_if.advance_dist <= adv;
        req_if.start_index  <= si;
        do @(posedge i_clk); while (!req_if.ready);
        pending_aims = {pending_aims, predict_aim(kind, x, y, adv, si)};
        items_sent++;
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (pending_aims.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_lookahead(input logic [30:0] v);
        drain_results();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        look_r = v;
    endtask

    function automatic logic signed [31:0] near(input int units);
        return $signed($urandom_range(0, 2 * units * U)) - units * U;
    endfunction

    task automatic send_noise();
        send_req(t_req'($urandom_range(0, 3)), $urandom, $urandom,
                 31'($urandom), 6'($urandom));
    endtask

    // One well-formed run: build a short path, start on it, then chase the aim point
    task automatic run_path(input int max_pts);
        int                 n;
        logic signed [31:0] wx, wy;
        n = $urandom_range(1, max_pts);
        wx = near(100);
        wy = near(100);
        send_req(REQ_CLEAR, $urandom, $urandom, 31'($urandom), 6'($urandom));
        for (int k = 0; k < n; k++) begin
            wx = wx + near(20);
            wy = wy + near(20);
            send_req(REQ_APPEND, wx, wy,
                     ($urandom_range(0, 9) == 0) ? 31'($urandom)
                                                 : 31'($urandom_range(0, 4 * U)),
                     6'($urandom));
        end
        send_req(REQ_START, near(120), near(120), 31'($urandom),
                 ($urandom_range(0, 5) == 0) ? 6'($urandom) : 6'($urandom_range(0, n)));
        repeat ($urandom_range(3, 15)) begin
            if ($urandom_range(0, 15) == 0) begin
                send_req(REQ_UPDATE, $urandom, $urandom, 31'($urandom), 6'($urandom));
            end else begin
                send_req(REQ_UPDATE, 32'(aim_x) + near(15), 32'(aim_y) + near(15),
                         31'($urandom), 6'($urandom));
            end
        end
    endtask

    task automatic run_random(input int count);
        int goal;
        goal = items_sent + count;
        while (items_sent < goal) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            else run_path(10);
        end
    endtask

    task automatic test_directed();
        send_req(REQ_UPDATE, 0, 0, 0, 0);
        send_req(REQ_START, 5 * U, -5 * U, 0, 0);
        send_req(REQ_CLEAR, 0, 0, 0, 0);
        send_req(REQ_APPEND, 10 * U, 0, U, 0);
        send_req(REQ_APPEND, 10 * U, 0, U, 0);
        send_req(REQ_START, 0, 0, 0, 0);
        send_req(REQ_UPDATE, 0, 0, 0, 0);
        send_req(REQ_UPDATE, 19 * U / 2, 0, 0, 0);
        // zero-length second segment, pose outside lookahead
        send_req(REQ_UPDATE, 30 * U, 0, 0, 0);
        send_req(REQ_UPDATE, 10 * U, 0, 0, 0);
        send_req(REQ_UPDATE, 0, 0, 0, 0);
        send_req(REQ_CLEAR, 0, 0, 0, 0);
        send_req(REQ_APPEND, 40 * U, 0, U, 0);
        send_req(REQ_START, 0, 0, 0, 6'd63);
        send_req(REQ_UPDATE, 0, 5 * U, 0, 0);
        send_req(REQ_UPDATE, 0, 20 * U, 0, 0);
        send_req(REQ_CLEAR, 0, 0, 0, 0);
        send_req(REQ_APPEND, 32'sh7fffffff, 32'sh80000000, 31'h7fffffff, 6'h3f);
        send_req(REQ_APPEND, 32'sh80000000, 32'sh7fffffff, 31'd0, 6'h3f);
        send_req(REQ_START, 32'sh80000000, 32'sh80000000, 31'h7fffffff, 6'd1);
        send_req(REQ_UPDATE, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff, 6'h3f);
        send_req(REQ_UPDATE, 32'sh80000000, 32'sh80000000, 0, 0);
        send_req(REQ_UPDATE, 0, 0, 0, 0);
    endtask

    task automatic test_table_full();
        send_req(REQ_CLEAR, 0, 0, 0, 0);
        for (int k = 0; k < MAX_POINTS + 2; k++) begin
            send_req(REQ_APPEND, near(200), near(200), 31'($urandom_range(0, 2 * U)), 0);
        end
        send_req(REQ_START, 0, 0, 0, 6'd63);
        repeat (5) send_req(REQ_UPDATE, 32'(aim_x) + near(10), 32'(aim_y) + near(10), 0, 0);
    endtask

    task automatic test_lookahead_sweep();
        logic [30:0] settings [5];
        settings = '{31'd0, 31'd1, 31'($urandom_range(2 * U, 40 * U)), 31'h7fffffff,
                     31'(LOOK_RESET)};
        foreach (settings[k]) begin
            write_lookahead(settings[k]);
            run_random(100);
        end
    endtask

    task automatic test_backpressure();
        hold_req <= ~hold_req;
        no_gaps = 1'b1;
        repeat (2) run_path(4);
        no_gaps = 1'b0;
    endtask

    // Result sink: random stall phases, plus one long hold on request
    int   sink_phase_left;
    int   sink_pct;
    int   hold_left;
    logic hold_seen;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            sink_phase_left <= 0;
            sink_pct <= 100;
            hold_left <= 0;
            hold_seen <= hold_req;
        end else begin
            if (hold_seen != hold_req) begin
                hold_seen <= hold_req;
                hold_left <= 600;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
            end
            if (sink_phase_left == 0) begin
                sink_phase_left <= $urandom_range(50, 300);
                case ($urandom_range(0, 3))
                    0: sink_pct <= 100;
                    1: sink_pct <= 90;
                    2: sink_pct <= 50;
                    default: sink_pct <= 15;
                endcase
            end else begin
                sink_phase_left <= sink_phase_left - 1;
            end
            res_if.ready <= (hold_left == 0 && hold_seen == hold_req) &&
                            ($urandom_range(1, 100) <= sink_pct);
        end
    end

    always @(posedge i_clk) begin
        t_aim_rec want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_aims.size() == 0) begin
                failed = 1'b1;
                if (mismatches < MAX_SHOWN) $display("unexpected result beat");
                mismatches++;
            end else begin
                want = pending_aims.pop_front();
                if (res_if.target_x !== want.tx || res_if.target_y !== want.ty ||
                    res_if.segment_index !== want.seg || res_if.status !== want.st) begin
                    failed = 1'b1;
                    if (mismatches < MAX_SHOWN) begin
                        $display(
                            "mismatch: expected x=%h y=%h seg=%0d st=%0d, got x=%h y=%h seg=%0d st=%0d",
                            want.tx, want.ty, want.seg, want.st, res_if.target_x,
                            res_if.target_y, res_if.segment_index, res_if.status);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: cycles with no beat on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        req_if.valid        <= 1'b0;
        req_if.req_type     <= REQ_CLEAR;
        req_if.coord_x      <= '0;
        req_if.coord_y      <= '0;
        req_if.advance_dist <= '0;
        req_if.start_index  <= '0;
        cfg_if.valid        <= 1'b0;
        cfg_if.data         <= '0;
        hold_req = 1'b0;
        failed = 1'b0;
        mismatches = 0;
        items_sent = 0;
        burst_left = 0;
        no_gaps = 1'b0;
        idle_cycles = 0;
        path_len = 0;
        seg_cur = 0;
        org_x = 0;
        org_y = 0;
        aim_x = 0;
        aim_y = 0;
        look_r = LOOK_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_table_full();
        test_backpressure();
        test_lookahead_sweep();
        test_backpressure();
        drain_results();
        if (!failed && pending_aims.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
